// File: hw/rtl/t3pk_pkg.sv
// Shared types, codes and lookup tables for the top-three peak tracker.
// Used by t3pk_merge and top3_peak_tracker_merge; no other dependencies.
`timescale 1ns / 1ps

package t3pk_pkg;

  // The tracker always keeps exactly three peaks.
  localparam int NUM_PEAKS = 3;
  localparam int SLOT_W    = 2;

  typedef logic [SLOT_W-1:0] slot_t;

  // Slot code that names the candidate as a route source. As a rank it means
  // the candidate is below every slot, and as an adjacency it means no match.
  localparam slot_t SLOT_NEW  = 2'd3;
  localparam slot_t SLOT_NONE = 2'd3;

  // Merge actions, in the order of the select table.
  typedef enum logic [2:0] {
    SEL_DROP,     // candidate discarded
    SEL_INS0,     // insert at slot 0, push the rest down
    SEL_INS1,     // insert at slot 1, push the rest down
    SEL_INS2,     // insert at slot 2
    SEL_REP0,     // replace adjacent slot 0
    SEL_TOP_ADJ1, // go to slot 0, old slot 0 moves down, old slot 1 dropped
    SEL_REP1      // replace adjacent slot 1
  } sel_t;

  // Select table indexed by rank and by the first adjacent slot.
  function automatic sel_t sel_lookup(slot_t rank, slot_t adj);
    sel_t s;
    s = SEL_DROP;
    unique case (rank)
      2'd0: begin
        unique case (adj)
          2'd0:    s = SEL_REP0;
          2'd1:    s = SEL_TOP_ADJ1;
          default: s = SEL_INS0;
        endcase
      end
      2'd1: begin
        unique case (adj)
          2'd0:    s = SEL_DROP;
          2'd1:    s = SEL_REP1;
          default: s = SEL_INS1;
        endcase
      end
      2'd2: begin
        if (adj == 2'd2 || adj == SLOT_NONE) begin
          s = SEL_INS2;
        end
      end
      default: s = SEL_DROP;
    endcase
    return s;
  endfunction

  // Source of each new slot for a merge action; packed slot 2 down to slot 0.
  function automatic slot_t route_src(sel_t sel, slot_t slot);
    logic [3*SLOT_W-1:0] r;
    unique case (sel)
      SEL_INS0:     r = {2'd1, 2'd0, SLOT_NEW};
      SEL_INS1:     r = {2'd1, SLOT_NEW, 2'd0};
      SEL_INS2:     r = {SLOT_NEW, 2'd1, 2'd0};
      SEL_REP0:     r = {2'd2, 2'd1, SLOT_NEW};
      SEL_TOP_ADJ1: r = {2'd2, 2'd0, SLOT_NEW};
      SEL_REP1:     r = {2'd2, SLOT_NEW, 2'd0};
      default:      r = {2'd2, 2'd1, 2'd0};
    endcase
    return r[slot*SLOT_W +: SLOT_W];
  endfunction

endpackage

// File: hw/rtl/top3_peak_tracker_merge.sv
// Top level of the top-three correlation peak tracker: stream ports, input
// register and the peak store. Depends on t3pk_pkg and t3pk_merge.
`timescale 1ns / 1ps

// The tracker takes one beat per clock cycle while out_tready is high and
// returns one beat per input beat, through the input register and then the
// peak store. An input beat with tuser high clears the store; otherwise its
// tdata carries a candidate peak that is ranked, checked for adjacency and
// merged combinationally between the input register and the peak store. The
// rate is set by the update of the three stored peaks, which every beat reads
// and writes. The output beat is the whole store after the update, largest
// peak first, with the shared exponent, and it holds while out_tready is low.
module top3_peak_tracker_merge #(
  parameter int AMP_BITS   = 16,
  parameter int EXP_BITS   = 4,
  parameter int FREQ_BITS  = 8,
  parameter int PHASE_BITS = 13,
  localparam int IN_TDATA_W =
    ((AMP_BITS + EXP_BITS + FREQ_BITS + PHASE_BITS + 7) / 8) * 8,
  localparam int OUT_BITS =
    3 * (AMP_BITS + FREQ_BITS + PHASE_BITS) + EXP_BITS,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // amplitude, exponent, freq_bin, code_phase, zero padding
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // first_amp, first_freq, first_phase, second_amp, second_freq,
  // second_phase, third_amp, third_freq, third_phase, shared_exp, zero padding
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  import t3pk_pkg::*;

  localparam int PEAK_W = AMP_BITS + FREQ_BITS + PHASE_BITS;

  logic                  in_valid_r;
  logic                  in_action_r;
  logic [AMP_BITS-1:0]   in_amp_r;
  logic [EXP_BITS-1:0]   in_exp_r;
  logic [FREQ_BITS-1:0]  in_freq_r;
  logic [PHASE_BITS-1:0] in_phase_r;
  logic                  out_valid_r;
  logic [AMP_BITS-1:0]   amp_r   [NUM_PEAKS];
  logic [FREQ_BITS-1:0]  freq_r  [NUM_PEAKS];
  logic [PHASE_BITS-1:0] phase_r [NUM_PEAKS];
  logic [EXP_BITS-1:0]   exp_r;
  logic [AMP_BITS-1:0]   amp_nxt   [NUM_PEAKS];
  logic [FREQ_BITS-1:0]  freq_nxt  [NUM_PEAKS];
  logic [PHASE_BITS-1:0] phase_nxt [NUM_PEAKS];
  logic [EXP_BITS-1:0]   exp_nxt;
  logic                  advance;

  // The registered beat moves into the store when the output slot is free.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_action_r <= in_tuser;
      in_amp_r    <= in_tdata[AMP_BITS-1:0];
      in_exp_r    <= in_tdata[AMP_BITS +: EXP_BITS];
      in_freq_r   <= in_tdata[AMP_BITS + EXP_BITS +: FREQ_BITS];
      in_phase_r  <= in_tdata[AMP_BITS + EXP_BITS + FREQ_BITS +: PHASE_BITS];
    end
  end

  // Ranking and merge of the registered candidate against the store.
  t3pk_merge #(
    .AMP_BITS   (AMP_BITS),
    .EXP_BITS   (EXP_BITS),
    .FREQ_BITS  (FREQ_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_merge (
    .cand_amp   (in_amp_r),
    .cand_exp   (in_exp_r),
    .cand_freq  (in_freq_r),
    .cand_phase (in_phase_r),
    .st_amp     (amp_r),
    .st_freq    (freq_r),
    .st_phase   (phase_r),
    .st_exp     (exp_r),
    .nx_amp     (amp_nxt),
    .nx_freq    (freq_nxt),
    .nx_phase   (phase_nxt),
    .nx_exp     (exp_nxt)
  );

  // Peak store; it doubles as the result register, since it only changes
  // when the previous result has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PEAKS; k++) begin
        amp_r[k]   <= '0;
        freq_r[k]  <= '0;
        phase_r[k] <= '0;
      end
      exp_r <= '0;
    end else if (advance) begin
      for (int k = 0; k < NUM_PEAKS; k++) begin
        amp_r[k]   <= in_action_r ? '0 : amp_nxt[k];
        freq_r[k]  <= in_action_r ? '0 : freq_nxt[k];
        phase_r[k] <= in_action_r ? '0 : phase_nxt[k];
      end
      exp_r <= in_action_r ? '0 : exp_nxt;
    end
  end

  // Output beat valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

  // Pack the store into the output beat, slot 0 in the lowest bits.
  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < NUM_PEAKS; k++) begin
      out_tdata[k*PEAK_W +: AMP_BITS]                     = amp_r[k];
      out_tdata[k*PEAK_W + AMP_BITS +: FREQ_BITS]         = freq_r[k];
      out_tdata[k*PEAK_W + AMP_BITS + FREQ_BITS +: PHASE_BITS] = phase_r[k];
    end
    out_tdata[NUM_PEAKS*PEAK_W +: EXP_BITS] = exp_r;
  end

endmodule

// File: hw/rtl/t3pk_merge.sv
// Next-state logic of the peak store: ranking, adjacency, select and routing.
// Purely combinational; depends on t3pk_pkg.
`timescale 1ns / 1ps

module t3pk_merge #(
  parameter int AMP_BITS   = 16,
  parameter int EXP_BITS   = 4,
  parameter int FREQ_BITS  = 8,
  parameter int PHASE_BITS = 13
) (
  input  logic [AMP_BITS-1:0]   cand_amp,
  input  logic [EXP_BITS-1:0]   cand_exp,
  input  logic [FREQ_BITS-1:0]  cand_freq,
  input  logic [PHASE_BITS-1:0] cand_phase,
  input  logic [AMP_BITS-1:0]   st_amp   [t3pk_pkg::NUM_PEAKS],
  input  logic [FREQ_BITS-1:0]  st_freq  [t3pk_pkg::NUM_PEAKS],
  input  logic [PHASE_BITS-1:0] st_phase [t3pk_pkg::NUM_PEAKS],
  input  logic [EXP_BITS-1:0]   st_exp,
  output logic [AMP_BITS-1:0]   nx_amp   [t3pk_pkg::NUM_PEAKS],
  output logic [FREQ_BITS-1:0]  nx_freq  [t3pk_pkg::NUM_PEAKS],
  output logic [PHASE_BITS-1:0] nx_phase [t3pk_pkg::NUM_PEAKS],
  output logic [EXP_BITS-1:0]   nx_exp
);

  import t3pk_pkg::*;

  // A step of one at the widened compare width, so that no index wraps.
  localparam logic [FREQ_BITS:0]  FREQ_ONE  = {{FREQ_BITS{1'b0}}, 1'b1};
  localparam logic [PHASE_BITS:0] PHASE_ONE = {{PHASE_BITS{1'b0}}, 1'b1};

  logic [NUM_PEAKS-1:0] ge;
  logic [NUM_PEAKS-1:0] near;
  logic [EXP_BITS-1:0]  exp_dn;
  logic [EXP_BITS-1:0]  exp_up;
  logic                 st_exp_ge;
  slot_t                rank;
  slot_t                adj;
  sel_t                 sel;
  logic [AMP_BITS-1:0]  amp_al;
  logic [AMP_BITS-1:0]  cand_shr;
  logic [EXP_BITS-1:0]  exp_new;
  logic [EXP_BITS-1:0]  grow;
  slot_t                src;

  // Exponent differences in both directions; only one is used at a time.
  assign exp_dn    = st_exp - cand_exp;
  assign exp_up    = cand_exp - st_exp;
  assign st_exp_ge = (st_exp >= cand_exp);
  assign cand_shr  = cand_amp >> exp_dn;

  // Aligned compare per slot (stored peak wins ties) and adjacency test.
  always_comb begin
    for (int k = 0; k < NUM_PEAKS; k++) begin
      if (st_exp_ge) begin
        ge[k] = (st_amp[k] >= cand_shr);
      end else begin
        ge[k] = ((st_amp[k] >> exp_up) >= cand_amp);
      end
      near[k] = (({1'b0, cand_freq} == {1'b0, st_freq[k]}) ||
                 ({1'b0, cand_freq} == {1'b0, st_freq[k]} + FREQ_ONE) ||
                 ({1'b0, st_freq[k]} == {1'b0, cand_freq} + FREQ_ONE)) &&
                (({1'b0, cand_phase} == {1'b0, st_phase[k]}) ||
                 ({1'b0, cand_phase} == {1'b0, st_phase[k]} + PHASE_ONE) ||
                 ({1'b0, st_phase[k]} == {1'b0, cand_phase} + PHASE_ONE));
    end
  end

  // Rank: the lowest slot that still holds at least the candidate decides.
  always_comb begin
    priority if (ge[2]) begin
      rank = 2'd3;
    end else if (ge[1]) begin
      rank = 2'd2;
    end else if (ge[0]) begin
      rank = 2'd1;
    end else begin
      rank = 2'd0;
    end
  end

  // First adjacent slot from the top.
  always_comb begin
    priority if (near[0]) begin
      adj = 2'd0;
    end else if (near[1]) begin
      adj = 2'd1;
    end else if (near[2]) begin
      adj = 2'd2;
    end else begin
      adj = SLOT_NONE;
    end
  end

  assign sel = sel_lookup(rank, adj);

  // Align either the candidate or the kept stored peaks to the larger exponent.
  always_comb begin
    if (!st_exp_ge || exp_dn == '0) begin
      amp_al  = cand_amp;
      exp_new = cand_exp;
      grow    = exp_up;
    end else begin
      amp_al  = cand_shr;
      exp_new = st_exp;
      grow    = '0;
    end
  end

  // Route every new slot from the candidate or from an old slot.
  always_comb begin
    src = '0;
    for (int k = 0; k < NUM_PEAKS; k++) begin
      src = route_src(sel, slot_t'(k));
      if (sel == SEL_DROP) begin
        nx_amp[k]   = st_amp[k];
        nx_freq[k]  = st_freq[k];
        nx_phase[k] = st_phase[k];
      end else if (src == SLOT_NEW) begin
        nx_amp[k]   = amp_al;
        nx_freq[k]  = cand_freq;
        nx_phase[k] = cand_phase;
      end else begin
        nx_amp[k]   = st_amp[src] >> grow;
        nx_freq[k]  = st_freq[src];
        nx_phase[k] = st_phase[src];
      end
    end
    nx_exp = (sel == SEL_DROP) ? st_exp : exp_new;
  end

endmodule
